### hdl/pfcg_pkg.sv
// Shared types, constants and codes for the packet filler and checksum generator.
package pfcg_pkg;

  // Packet size constants
  localparam int unsigned HEADER_BYTES     = 24;
  localparam int unsigned SEC_HEADER_BYTES = 12;
  localparam int unsigned MAX_DATA_BYTES   = 524288;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 20;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned KIND_W = 2;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_HEADER_ON = 2'd1;

  // Checksum modes
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_8    = 2'd1,
    MODE_16   = 2'd2,
    MODE_32   = 2'd3
  } mode_t;

  // Output word kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_FILL     = 2'd1,
    KIND_CHECKSUM = 2'd2
  } kind_t;

  // Pending output work produced by one input word
  typedef struct packed {
    logic              pay;        // payload byte still to send
    logic [BYTE_W-1:0] pay_byte;
    logic [1:0]        fill_left;  // zero filler bytes still to send
    logic [2:0]        cs_left;    // checksum bytes still to send
    logic [SUM_W-1:0]  sum;        // checksum, lowest byte next
    logic [CNT_W-1:0]  plen;       // total packet length
    logic              term;       // work ends the packet
  } job_t;

endpackage

### hdl/pfcg_step.sv
// Per-word update of count and sum, and trailer sizing for one input word.
module pfcg_step (
  input  pfcg_pkg::mode_t                mode,
  input  logic                           sec_on,
  input  logic [pfcg_pkg::CNT_W-1:0]     byte_count,
  input  logic [pfcg_pkg::SUM_W-1:0]     running_sum,
  input  logic [pfcg_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           byte_present,
  input  logic                           last_byte,
  output pfcg_pkg::job_t                 job,
  output logic [pfcg_pkg::CNT_W-1:0]     byte_count_next,
  output logic [pfcg_pkg::SUM_W-1:0]     running_sum_next
);

  logic                         took;
  logic [4:0]                   shift;
  logic [pfcg_pkg::SUM_W-1:0]   addend;
  logic [pfcg_pkg::SUM_W-1:0]   sum_add;
  logic [pfcg_pkg::SUM_W-1:0]   sum_mask;
  logic [pfcg_pkg::CNT_W-1:0]   cnt_add;
  logic [2:0]                   csize;
  logic [1:0]                   low;
  logic [1:0]                   fill;
  logic [pfcg_pkg::CNT_W-1:0]   buf_len;
  logic [pfcg_pkg::CNT_W-1:0]   plen;

  // Take the byte unless the packet is already full
  assign took = byte_present &&
                (byte_count < pfcg_pkg::CNT_W'(pfcg_pkg::MAX_DATA_BYTES));

  // Place the byte in its lane of the checksum unit
  always_comb begin
    case (mode)
      pfcg_pkg::MODE_8:  shift = 5'd0;
      pfcg_pkg::MODE_16: shift = {1'b0, byte_count[0], 3'b000};
      default:           shift = {byte_count[1:0], 3'b000};
    endcase
  end

  assign addend  = pfcg_pkg::SUM_W'(data_byte) << shift;
  assign sum_add = running_sum + (took ? addend : '0);
  assign cnt_add = byte_count + pfcg_pkg::CNT_W'(took);

  // Checksum size and mask from the mode
  always_comb begin
    case (mode)
      pfcg_pkg::MODE_NONE: begin
        csize    = 3'd0;
        sum_mask = '0;
      end
      pfcg_pkg::MODE_8: begin
        csize    = 3'd1;
        sum_mask = pfcg_pkg::SUM_W'(32'h0000_00ff);
      end
      pfcg_pkg::MODE_16: begin
        csize    = 3'd2;
        sum_mask = pfcg_pkg::SUM_W'(32'h0000_ffff);
      end
      default: begin
        csize    = 3'd4;
        sum_mask = '1;
      end
    endcase
  end

  // Filler brings payload plus checksum up to 4-byte alignment
  assign low     = cnt_add[1:0] + csize[1:0];
  assign fill    = 2'(2'd0 - low);
  assign buf_len = cnt_add + pfcg_pkg::CNT_W'(csize) + pfcg_pkg::CNT_W'(fill);
  assign plen    = buf_len + pfcg_pkg::CNT_W'(pfcg_pkg::HEADER_BYTES) +
                   (sec_on ? pfcg_pkg::CNT_W'(pfcg_pkg::SEC_HEADER_BYTES) : '0);

  // Assemble the work for this word
  always_comb begin
    job.pay       = took;
    job.pay_byte  = data_byte;
    job.fill_left = last_byte ? fill : 2'd0;
    job.cs_left   = last_byte ? csize : 3'd0;
    job.sum       = sum_add & sum_mask;
    job.plen      = plen;
    job.term      = last_byte;
  end

  // Clear state at the end of a packet
  assign byte_count_next  = last_byte ? '0 : cnt_add;
  assign running_sum_next = last_byte ? '0 : sum_add;

endmodule

### hdl/packet_filler_checksum_generator_core.sv
// Top level: payload pass-through with zero filler and checksum trailer.
// Accepted work is registered, and its bytes leave through the output register.
// Throughput: one input word per cycle while payload streams and the output is not stalled;
// a word marked last holds the input until its payload, filler and checksum bytes are all
// sent by the one-byte-per-cycle trailer sequencer, which waits while the output is stalled.
// Reset (rst, synchronous): clears count, sum, pending work, output valid and
// configuration (checksum off, secondary header off).
module packet_filler_checksum_generator_core (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfcg_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic [0:0]                      s_tuser,   // [0] byte_present
  input  logic                            s_tlast,   // last_byte
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [7:0] out_byte, [27:8] packet_length
  output logic [1:0]                      m_tuser,   // [1:0] out_kind
  output logic                            m_tlast    // out_last
);

  pfcg_pkg::mode_t                 mode;
  logic                            sec_on;
  logic [pfcg_pkg::CNT_W-1:0]      byte_count;
  logic [pfcg_pkg::SUM_W-1:0]      running_sum;
  logic [pfcg_pkg::CNT_W-1:0]      byte_count_next;
  logic [pfcg_pkg::SUM_W-1:0]      running_sum_next;
  pfcg_pkg::job_t                  job;
  pfcg_pkg::job_t                  job_new;
  logic [3:0]                      remaining;
  logic                            busy;
  logic                            one_left;
  logic                            adv;
  logic                            in_acc;
  logic [pfcg_pkg::BYTE_W-1:0]     emit_byte;
  pfcg_pkg::kind_t                 emit_kind;
  logic                            emit_last;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= pfcg_pkg::MODE_NONE;
      sec_on <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == pfcg_pkg::CFG_CHECKSUM_MODE) begin
        mode <= pfcg_pkg::mode_t'(cfg_data[1:0]);
      end else if (cfg_index == pfcg_pkg::CFG_SEC_HEADER_ON) begin
        sec_on <= cfg_data[0];
      end
    end
  end

  // Per-word arithmetic
  pfcg_step u_step (
    .mode             (mode),
    .sec_on           (sec_on),
    .byte_count       (byte_count),
    .running_sum      (running_sum),
    .data_byte        (s_tdata[7:0]),
    .byte_present     (s_tuser[0]),
    .last_byte        (s_tlast),
    .job              (job_new),
    .byte_count_next  (byte_count_next),
    .running_sum_next (running_sum_next)
  );

  // Sequencer status
  assign remaining = 4'(job.pay) + 4'(job.fill_left) + 4'(job.cs_left);
  assign busy      = (remaining != 4'd0);
  assign one_left  = (remaining == 4'd1);
  assign adv       = busy && (!m_tvalid || m_tready);
  assign s_tready  = !busy || (adv && one_left);
  assign in_acc    = s_tvalid && s_tready;

  // Pick the next byte to send: payload, then filler, then checksum
  always_comb begin
    emit_last = job.term && one_left;
    if (job.pay) begin
      emit_byte = job.pay_byte;
      emit_kind = pfcg_pkg::KIND_PAYLOAD;
    end else if (job.fill_left != 2'd0) begin
      emit_byte = '0;
      emit_kind = pfcg_pkg::KIND_FILL;
    end else begin
      emit_byte = job.sum[7:0];
      emit_kind = pfcg_pkg::KIND_CHECKSUM;
    end
  end

  // Count and sum state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
    end else if (in_acc) begin
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // Load new work on accept, otherwise advance one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      job.pay       <= 1'b0;
      job.fill_left <= 2'd0;
      job.cs_left   <= 3'd0;
      job.term      <= 1'b0;
    end else if (in_acc) begin
      job <= job_new;
    end else if (adv) begin
      if (job.pay) begin
        job.pay <= 1'b0;
      end else if (job.fill_left != 2'd0) begin
        job.fill_left <= job.fill_left - 2'd1;
      end else begin
        job.cs_left <= job.cs_left - 3'd1;
        job.sum     <= job.sum >> 8;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'b0000, (emit_last ? job.plen : {pfcg_pkg::CNT_W{1'b0}}), emit_byte};
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

endmodule

### hdl/pfcg_checker.sv
// Port-level checker for the packet filler and checksum generator, with its bind.
module pfcg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [31:0]                     m_tdata,
  input logic [1:0]                      m_tuser,
  input logic                            m_tlast
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Filler bytes are zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == pfcg_pkg::KIND_FILL) |-> (m_tdata[7:0] == 8'd0))
    else $error("filler byte not zero");

  // Length only on the final word
  a_len_only_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[27:8] == 20'd0))
    else $error("packet length on non-final word");

  // Final length covers the header and is word aligned
  a_len_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      (m_tdata[27:8] >= 20'(pfcg_pkg::HEADER_BYTES)) && (m_tdata[9:8] == 2'b00))
    else $error("bad packet length");

  // No input accepted while a trailer is still pending behind a stalled output
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !m_tlast && (m_tuser != pfcg_pkg::KIND_PAYLOAD)
      |-> !s_tready)
    else $error("input accepted during trailer");

endmodule

bind packet_filler_checksum_generator_core pfcg_checker u_pfcg_checker (.*);

### dv/tb.sv
// Testbench for the packet filler and checksum generator: directed table, random packets, full-rate stream.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfcg_pkg::*;

  // Cycles to let a trailer drain before a register write
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_BYTES    = 130;
  localparam int FULL_RATE_BYTES = 16;

  typedef struct {
    logic [BYTE_W-1:0] dat;
    kind_t             kind;
    logic              eop;
    logic [CNT_W-1:0]  plen;
  } out_word_t;

  typedef enum {OP_WORD, OP_REG} row_op_t;

  typedef struct {
    row_op_t                op;
    logic [BYTE_W-1:0]      d;
    logic                   p;
    logic                   l;
    logic [CFG_IDX_W-1:0]   ri;
    logic [CFG_DATA_W-1:0]  rv;
    bit                     typed;
    int                     n_out;
    logic [BYTE_W-1:0]      tail;
    kind_t                  tail_kind;
    logic [CNT_W-1:0]       tail_len;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] data_byte
  logic [0:0]            s_tuser = '0;   // [0] byte_present
  logic                  s_tlast = 1'b0; // last_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;        // [7:0] out_byte, [27:8] packet_length
  logic [1:0]            m_tuser;        // [1:0] out_kind
  logic                  m_tlast;        // out_last

  // Predictor state and expected output words
  mode_t             cur_mode = MODE_NONE;
  logic              sec_on = 1'b0;
  logic [CNT_W-1:0]  pkt_count = '0;
  logic [SUM_W-1:0]  pkt_sum = '0;
  out_word_t         expected_bytes[$];

  int  mismatches = 0;
  bit  full_rate = 1'b0;
  int  burst_left = 0;
  int  stall_run = 0;

  packet_filler_checksum_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  function automatic void push_byte(logic [BYTE_W-1:0] d, kind_t k);
    out_word_t w;
    w.dat  = d;
    w.kind = k;
    w.eop  = 1'b0;
    w.plen = '0;
    expected_bytes.push_back(w);
  endfunction

  // Pass a byte through, and on the last word append filler and checksum
  function automatic int predict_bytes(logic [BYTE_W-1:0] d, logic present, logic last);
    int               n;
    int unsigned      shift, csize, buf_len, fill_n;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] plen;
    n = 0;
    if (present && pkt_count < MAX_DATA_BYTES) begin
      case (cur_mode)
        MODE_8:  shift = 0;
        MODE_16: shift = 8 * pkt_count[0];
        default: shift = 8 * pkt_count[1:0];
      endcase
      pkt_sum += SUM_W'(d) << shift;
      pkt_count++;
      push_byte(d, KIND_PAYLOAD);
      n++;
    end
    if (!last) return n;
    csize   = (cur_mode == MODE_NONE) ? 0 : (1 << (int'(cur_mode) - 1));
    buf_len = (pkt_count + csize + 3) & 32'hffff_fffc;
    fill_n  = buf_len - pkt_count - csize;
    for (int i = 0; i < fill_n; i++) begin
      push_byte('0, KIND_FILL);
      n++;
    end
    sum = pkt_sum;
    if (cur_mode == MODE_8) sum &= 32'h0000_00ff;
    else if (cur_mode == MODE_16) sum &= 32'h0000_ffff;
    for (int i = 0; i < csize; i++) begin
      push_byte(sum[8*i +: 8], KIND_CHECKSUM);
      n++;
    end
    plen = CNT_W'(HEADER_BYTES + buf_len + (sec_on ? SEC_HEADER_BYTES : 0));
    if (n > 0) begin
      expected_bytes[expected_bytes.size()-1].eop  = 1'b1;
      expected_bytes[expected_bytes.size()-1].plen = plen;
    end
    pkt_count = '0;
    pkt_sum   = '0;
    return n;
  endfunction

  // Offer one input word in bursts with random gaps; predict on acceptance
  task automatic send_word(input logic [BYTE_W-1:0] d, input logic p, input logic l,
                           output int n);
    int gap;
    if (burst_left == 0) begin
      gap = full_rate ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid   <= 1'b1;
    s_tdata    <= d;
    s_tuser[0] <= p;
    s_tlast    <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = predict_bytes(d, p, l);
  endtask

  // Write a register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHECKSUM_MODE) cur_mode = mode_t'(val);
    else if (idx == CFG_SEC_HEADER_ON) sec_on = val[0];
  endtask

  function automatic row_t word_row(logic [BYTE_W-1:0] d, logic p, logic l);
    row_t r;
    r = '{OP_WORD, d, p, l, CFG_CHECKSUM_MODE, '0, 1'b0, 0, '0, KIND_PAYLOAD, '0};
    return r;
  endfunction

  function automatic row_t typed_row(logic [BYTE_W-1:0] d, logic p, logic l, int n,
                                     logic [BYTE_W-1:0] tail, kind_t k, logic [CNT_W-1:0] len);
    row_t r;
    r = '{OP_WORD, d, p, l, CFG_CHECKSUM_MODE, '0, 1'b1, n, tail, k, len};
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{OP_REG, '0, 1'b0, 1'b0, idx, val, 1'b0, 0, '0, KIND_PAYLOAD, '0};
    return r;
  endfunction

  // Stall the output on a pattern of short stalls, toggling and long ready stretches
  always @(posedge clk) begin
    if (rst || full_rate) begin
      m_tready  <= 1'b1;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_tready  <= 1'b0;
          stall_run <= $urandom_range(1, 8);
        end
        1: begin
          m_tready  <= 1'b1;
          stall_run <= $urandom_range(20, 60);
        end
        default: begin
          m_tready  <= ~m_tready;
          stall_run <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected word byte=%02h kind=%0d last=%0b len=%0d",
                                m_tdata[7:0], m_tuser, m_tlast, m_tdata[27:8]));
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.dat || m_tuser !== want.kind ||
            m_tlast !== want.eop || m_tdata[27:8] !== want.plen)
          flag_mismatch($sformatf(
            "exp byte=%02h kind=%0d last=%0b len=%0d, got byte=%02h kind=%0d last=%0b len=%0d",
            want.dat, want.kind, want.eop, want.plen,
            m_tdata[7:0], m_tuser, m_tlast, m_tdata[27:8]));
      end
    end
  end

  // Stimulus
  initial begin
    row_t        directed [29];
    int          n, pkt_len, sent;
    bit          end_empty;

    directed = '{
      // empty packet with no checksum: nothing comes out
      typed_row(8'h00, 1'b0, 1'b1, 0, 8'h00, KIND_PAYLOAD, 20'd0),
      typed_row(8'hff, 1'b1, 1'b1, 4, 8'h00, KIND_FILL, 20'd28),
      reg_row(CFG_CHECKSUM_MODE, MODE_8),
      reg_row(CFG_SEC_HEADER_ON, 2'd1),
      typed_row(8'h00, 1'b1, 1'b0, 1, 8'h00, KIND_PAYLOAD, 20'd0),
      typed_row(8'hff, 1'b1, 1'b1, 3, 8'hff, KIND_CHECKSUM, 20'd40),
      reg_row(CFG_CHECKSUM_MODE, MODE_16),
      word_row(8'h01, 1'b1, 1'b0),
      word_row(8'h80, 1'b1, 1'b0),
      typed_row(8'haa, 1'b1, 1'b1, 6, 8'h80, KIND_CHECKSUM, 20'd44),
      reg_row(CFG_CHECKSUM_MODE, MODE_32),
      reg_row(CFG_SEC_HEADER_ON, 2'd0),
      word_row(8'h55, 1'b1, 1'b0),
      word_row(8'haa, 1'b1, 1'b0),
      word_row(8'h0f, 1'b1, 1'b0),
      typed_row(8'hf0, 1'b1, 1'b1, 5, 8'hf0, KIND_CHECKSUM, 20'd32),
      typed_row(8'h3c, 1'b0, 1'b0, 0, 8'h00, KIND_PAYLOAD, 20'd0),
      // empty packet still gets a checksum trailer
      typed_row(8'h00, 1'b0, 1'b1, 4, 8'h00, KIND_CHECKSUM, 20'd28),
      // change the lane layout inside a packet
      reg_row(CFG_CHECKSUM_MODE, MODE_8),
      word_row(8'h10, 1'b1, 1'b0),
      reg_row(CFG_CHECKSUM_MODE, MODE_16),
      word_row(8'h20, 1'b1, 1'b0),
      word_row(8'h30, 1'b1, 1'b1),
      reg_row(CFG_CHECKSUM_MODE, MODE_NONE),
      word_row(8'h12, 1'b1, 1'b0),
      word_row(8'h00, 1'b0, 1'b0),
      word_row(8'h34, 1'b1, 1'b1),
      // end a packet with a word that carries no byte
      word_row(8'h9a, 1'b1, 1'b0),
      typed_row(8'h00, 1'b0, 1'b1, 3, 8'h00, KIND_FILL, 20'd28)
    };

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed[i]) begin
      if (directed[i].op == OP_REG) begin
        write_reg(directed[i].ri, directed[i].rv);
      end else begin
        send_word(directed[i].d, directed[i].p, directed[i].l, n);
        if (directed[i].typed) begin
          if (n != directed[i].n_out)
            flag_mismatch($sformatf("row %0d: exp %0d words, predicted %0d",
                                    i, directed[i].n_out, n));
          else if (n > 0 &&
                   (expected_bytes[$].dat !== directed[i].tail ||
                    expected_bytes[$].kind !== directed[i].tail_kind ||
                    expected_bytes[$].plen !== directed[i].tail_len))
            flag_mismatch($sformatf("row %0d: exp tail %02h/%0d/%0d, predicted %02h/%0d/%0d",
                                    i, directed[i].tail, directed[i].tail_kind,
                                    directed[i].tail_len, expected_bytes[$].dat,
                                    expected_bytes[$].kind, expected_bytes[$].plen));
        end
      end
    end

    // Random packets, mostly short, with noise words and register changes
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_CHECKSUM_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0)
          write_reg(CFG_SEC_HEADER_ON, CFG_DATA_W'($urandom_range(0, 1)));
      end
      pkt_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      end_empty = (pkt_len == 0) || ($urandom_range(0, 5) == 0);
      for (int i = 0; i < pkt_len; i++) begin
        if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0, n);
        if ($urandom_range(0, 29) == 0)
          write_reg(CFG_CHECKSUM_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        send_word(8'($urandom), 1'b1, (i == pkt_len - 1) && !end_empty, n);
        sent++;
      end
      if (end_empty) begin
        send_word(8'($urandom), 1'b0, 1'b1, n);
        sent++;
      end
    end

    // Stream one packet back to back with the receiver always ready
    write_reg(CFG_CHECKSUM_MODE, MODE_32);
    write_reg(CFG_SEC_HEADER_ON, 2'd1);
    full_rate = 1'b1;
    for (int k = 0; k < FULL_RATE_BYTES; k++)
      send_word(8'($urandom), 1'b1, k == FULL_RATE_BYTES - 1, n);
    s_tvalid <= 1'b0;
    full_rate = 1'b0;

    // Drain and finish
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hdl/pfcg_pkg.sv
hdl/pfcg_step.sv
hdl/packet_filler_checksum_generator_core.sv
hdl/pfcg_checker.sv
dv/tb.sv
